>>> sv/feba_pkg.sv
// ----------------------------------------------------------------------------
// feba_pkg
// Shared codes and widths for the free-extent bitmap allocator.
// ----------------------------------------------------------------------------
package feba_pkg;

    localparam int BLK_W = 18;   // internal block numbers, room for start + len

    typedef logic [2:0] cmd_t;
    typedef logic [1:0] status_t;
    typedef logic [1:0] cfg_index_t;

    localparam cmd_t CMD_LOAD       = 3'd0;
    localparam cmd_t CMD_FIND       = 3'd1;
    localparam cmd_t CMD_MARK_USED  = 3'd2;
    localparam cmd_t CMD_MARK_FREE  = 3'd3;
    localparam cmd_t CMD_COUNT      = 3'd4;

    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_NO_FREE = 2'd1;
    localparam status_t ST_SKIPPED = 2'd2;

    localparam cfg_index_t CFG_SPWB       = 2'd0;
    localparam cfg_index_t CFG_CDR_MODE   = 2'd1;
    localparam cfg_index_t CFG_LAST_BLOCK = 2'd2;

endpackage

>>> sv/free_extent_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// free_extent_bitmap_allocator
// Free-space bitmap in a 32-bit word memory. Load writes one word; mark,
// count and find walk it one block per cycle while the cached word hits.
// ----------------------------------------------------------------------------
// Mark, count and find pause on each cached-word miss to write back a dirty
//   word and fetch the probed one through the registered memory read port.
// Throughput: one command at a time; the next is taken once the result sits
//   in the output register.
// Reset: control and configuration clear synchronously; the bitmap memory
//   is not cleared and is undefined until loaded.
module free_extent_bitmap_allocator #(
    parameter int BITMAP_BITS       = 65536,
    parameter int MAX_EXTENT_BLOCKS = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_command,
    input  logic [15:0] s_range_start,
    input  logic [16:0] s_range_len,
    input  logic [16:0] s_search_limit,
    input  logic        s_sequential,
    input  logic [10:0] s_word_index,
    input  logic [31:0] s_word_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [15:0] m_extent_start,
    output logic [16:0] m_extent_len,
    output logic [16:0] m_free_count
);

    localparam int WORDS = (BITMAP_BITS + 31) / 32;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BW    = feba_pkg::BLK_W;
    localparam logic [31:0] BITS32  = BITMAP_BITS;
    localparam logic [31:0] WORDS32 = WORDS;
    localparam logic [31:0] MAX32   = MAX_EXTENT_BLOCKS;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_INIT  = 4'd1;
    localparam logic [3:0] S_PASS  = 4'd2;
    localparam logic [3:0] S_TOP   = 4'd3;
    localparam logic [3:0] S_FULL  = 4'd4;
    localparam logic [3:0] S_SKIP  = 4'd5;
    localparam logic [3:0] S_RUN   = 4'd6;
    localparam logic [3:0] S_UPD   = 4'd7;
    localparam logic [3:0] S_PEND  = 4'd8;
    localparam logic [3:0] S_MARK  = 4'd9;
    localparam logic [3:0] S_FLUSH = 4'd10;
    localparam logic [3:0] S_COUNT = 4'd11;
    localparam logic [3:0] S_CAP   = 4'd12;
    localparam logic [3:0] S_DONE  = 4'd13;

    logic [31:0] mem [WORDS];
    logic [31:0] rd_q;
    logic        wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0] wr_data;

    logic [3:0]  state_reg, state_next, ret_reg, ret_next;
    logic [8:0]  spwb_reg;
    logic        cdr_reg;
    logic [16:0] last_reg;
    logic        valid_reg, valid_next, dirty_reg, dirty_next;
    logic        align_reg, align_next, tried_reg, tried_next;
    logic        m_valid_reg, m_valid_next;

    logic [15:0] start_reg, start_next;
    logic [16:0] len_reg, len_next, lim_reg, lim_next, count_reg, count_next;
    logic        seq_reg, seq_next, mval_reg, mval_next;
    logic [8:0]  ps_reg, ps_next;
    logic [BW-1:0] i_reg, i_next, b_reg, b_next, f_reg, f_next, cnt_reg, cnt_next;
    logic [BW-1:0] run_reg, run_next, end_reg, end_next;
    logic [BW-1:0] mlba_reg, mlba_next, mlen_reg, mlen_next;
    logic [31:0] word_reg, word_next;
    logic [AW-1:0] waddr_reg, waddr_next, cap_reg, cap_next;
    logic [1:0]  rs_reg, rs_next;
    logic [15:0] rstart_reg, rstart_next;
    logic [16:0] rlen_reg, rlen_next, rcount_reg, rcount_next;
    logic [1:0]  ms_reg;
    logic [15:0] mst_reg;
    logic [16:0] ml_reg, mc_reg;

    // block probe through the cached word
    logic [BW-1:0] pblk;
    logic [31:0]   pword32, lword32;
    logic [AW-1:0] pword;
    logic          pout, phit, pfree;
    logic [8:0]    ps_c;
    logic [BW-1:0] lim18, len18, pmask, iround, fc, sum18, st7, lim7;

    assign cfg_ready      = 1'b1;
    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_status       = ms_reg;
    assign m_extent_start = mst_reg;
    assign m_extent_len   = ml_reg;
    assign m_free_count   = mc_reg;

    always_comb begin
        unique case (state_reg)
            S_SKIP:  pblk = f_reg;
            S_RUN:   pblk = f_reg + cnt_reg;
            default: pblk = b_reg;
        endcase
    end

    assign fc      = f_reg + cnt_reg;
    assign pword32 = {19'd0, pblk[BW-1:5]};
    assign pword   = pword32[AW-1:0];
    assign pout    = {14'd0, pblk} >= BITS32;
    assign phit    = pout || (valid_reg && (waddr_reg == pword));
    assign pfree   = !pout && word_reg[pblk[4:0]];
    assign lword32 = {21'd0, s_word_index};
    assign lim18   = {1'b0, lim_reg};
    assign len18   = {1'b0, len_reg};
    assign pmask   = {9'd0, ps_reg - 9'd1};
    assign iround  = (i_reg + pmask) & ~pmask;
    assign sum18   = {2'd0, s_range_start} + {1'b0, s_range_len};
    assign st7     = {2'd0, s_range_start} + 18'd7;
    assign lim7    = {1'b0, s_search_limit} + 18'd7;

    always_comb begin
        ps_c = 9'd1;
        for (int k = 0; k < 9; k++) begin
            if (spwb_reg[k]) ps_c = 9'(1 << k);
        end
    end

    always_comb begin
        state_next = state_reg;  ret_next = ret_reg;
        valid_next = valid_reg;  dirty_next = dirty_reg;
        align_next = align_reg;  tried_next = tried_reg;
        m_valid_next = m_valid_reg;
        start_next = start_reg;  len_next = len_reg;  lim_next = lim_reg;
        count_next = count_reg;  seq_next = seq_reg;  mval_next = mval_reg;
        ps_next = ps_reg;  i_next = i_reg;  b_next = b_reg;  f_next = f_reg;
        cnt_next = cnt_reg;  run_next = run_reg;  end_next = end_reg;
        mlba_next = mlba_reg;  mlen_next = mlen_reg;
        word_next = word_reg;  waddr_next = waddr_reg;  cap_next = cap_reg;
        rs_next = rs_reg;  rstart_next = rstart_reg;
        rlen_next = rlen_reg;  rcount_next = rcount_reg;
        wr_en = 1'b0;  wr_addr = waddr_reg;  wr_data = word_reg;

        if (m_valid_reg && m_ready) m_valid_next = 1'b0;

        // fetch the probed word on a miss, writing back a dirty one in the same cycle
        if ((state_reg == S_FULL || state_reg == S_SKIP || state_reg == S_RUN ||
             state_reg == S_MARK || state_reg == S_COUNT) && !phit) begin
            wr_en      = dirty_reg;
            dirty_next = 1'b0;
            valid_next = 1'b0;
            cap_next   = pword;
            ret_next   = state_reg;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    valid_next = 1'b0;
                    dirty_next = 1'b0;
                    rs_next = feba_pkg::ST_OK;  rstart_next = '0;
                    rlen_next = '0;  rcount_next = '0;
                    unique case (s_command)
                        feba_pkg::CMD_LOAD: begin
                            wr_en   = lword32 < WORDS32;
                            wr_addr = lword32[AW-1:0];
                            wr_data = s_word_data;
                            state_next = S_DONE;
                        end
                        feba_pkg::CMD_FIND: begin
                            start_next = s_range_start;
                            len_next   = s_range_len;
                            lim_next   = s_search_limit;
                            seq_next   = s_sequential;
                            state_next = S_INIT;
                        end
                        feba_pkg::CMD_MARK_USED, feba_pkg::CMD_MARK_FREE: begin
                            b_next    = {2'd0, s_range_start};
                            mval_next = (s_command == feba_pkg::CMD_MARK_FREE);
                            end_next  = sum18;
                            state_next = S_MARK;
                            if (sum18 > {1'b0, last_reg}) begin
                                end_next = {1'b0, last_reg};
                                if ({1'b0, s_range_start} > last_reg) begin
                                    rs_next    = feba_pkg::ST_SKIPPED;
                                    state_next = S_DONE;
                                end
                            end
                        end
                        feba_pkg::CMD_COUNT: begin
                            b_next     = {st7[BW-1:3], 3'd0};
                            end_next   = {lim7[BW-1:3], 3'd0};
                            count_next = '0;
                            state_next = S_COUNT;
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_INIT: begin
                ps_next    = ps_c;
                align_next = seq_reg || (((len_reg[8:0] & (ps_c - 9'd1)) == 9'd0) &&
                             !cdr_reg && (len_reg >= {7'd0, ps_c, 1'b0}));
                if ({15'd0, len_reg} > MAX32) len_next = MAX32[16:0];
                if ({15'd0, lim_reg} > BITS32) lim_next = BITS32[16:0];
                mlen_next = '0;
                mlba_next = '0;
                rs_next   = feba_pkg::ST_NO_FREE;
                state_next = (len_reg == 17'd0) ? S_DONE : S_PASS;
            end
            S_PASS: begin
                tried_next = 1'b0;
                i_next     = {2'd0, start_reg};
                state_next = S_TOP;
            end
            S_TOP: begin
                if ((align_reg ? iround : i_reg) >= lim18) begin
                    state_next = S_PEND;
                end else begin
                    i_next = align_reg ? iround : i_reg;
                    if (!tried_reg) begin
                        tried_next = 1'b1;
                        b_next     = align_reg ? iround : i_reg;
                        run_next   = '0;
                        state_next = S_FULL;
                    end else begin
                        f_next     = align_reg ? iround : i_reg;
                        state_next = S_SKIP;
                    end
                end
            end
            S_FULL: begin
                if (b_reg >= lim18) begin
                    f_next     = i_reg;
                    state_next = S_SKIP;
                end else if (!phit) begin
                    state_next = S_CAP;
                end else if (pfree) begin
                    if (run_reg + 18'd1 == len18) begin
                        rs_next     = feba_pkg::ST_OK;
                        rstart_next = 16'(b_reg + 18'd1 - len18);
                        rlen_next   = len_reg;
                        state_next  = S_DONE;
                    end else begin
                        run_next = run_reg + 18'd1;
                        b_next   = b_reg + 18'd1;
                    end
                end else begin
                    run_next = '0;
                    b_next   = b_reg + 18'd1;
                end
            end
            S_SKIP: begin
                if (f_reg >= lim18) state_next = S_PEND;
                else if (!phit) state_next = S_CAP;
                else if (!pfree) f_next = f_reg + 18'd1;
                else begin
                    cnt_next   = '0;
                    state_next = S_RUN;
                end
            end
            S_RUN: begin
                if (fc >= lim18) state_next = S_UPD;
                else if (!phit) state_next = S_CAP;
                else if (pfree) begin
                    cnt_next = cnt_reg + 18'd1;
                    if (cnt_reg + 18'd1 >= len18) state_next = S_UPD;
                end else state_next = S_UPD;
            end
            S_UPD: begin
                if (cnt_reg > mlen_reg) begin
                    mlen_next = cnt_reg;
                    mlba_next = f_reg;
                end
                i_next     = fc;
                state_next = S_TOP;
            end
            S_PEND: begin
                if (align_reg) begin
                    align_next = 1'b0;
                    state_next = S_PASS;
                end else begin
                    if (mlen_reg != '0) begin
                        rs_next     = feba_pkg::ST_OK;
                        rstart_next = mlba_reg[15:0];
                        rlen_next   = mlen_reg[16:0];
                    end
                    state_next = S_DONE;
                end
            end
            S_MARK: begin
                if (b_reg >= end_reg) state_next = S_FLUSH;
                else if (!phit) state_next = S_CAP;
                else begin
                    if (!pout) begin
                        word_next[b_reg[4:0]] = mval_reg;
                        dirty_next = 1'b1;
                    end
                    b_next = b_reg + 18'd1;
                end
            end
            S_FLUSH: begin
                wr_en      = dirty_reg;
                dirty_next = 1'b0;
                state_next = S_DONE;
            end
            S_COUNT: begin
                if (b_reg >= end_reg) begin
                    rcount_next = count_reg;
                    state_next  = S_DONE;
                end else if (!phit) state_next = S_CAP;
                else begin
                    if (pfree) count_next = count_reg + 17'd1;
                    b_next = b_reg + 18'd1;
                end
            end
            S_CAP: begin
                word_next  = rd_q;
                waddr_next = cap_reg;
                valid_next = 1'b1;
                state_next = ret_reg;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // bitmap memory, one write port and one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_q <= mem[pword];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ret_reg     <= S_IDLE;
            valid_reg   <= 1'b0;
            dirty_reg   <= 1'b0;
            align_reg   <= 1'b0;
            tried_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            spwb_reg    <= 9'd1;
            cdr_reg     <= 1'b0;
            last_reg    <= 17'd65535;
        end else begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            valid_reg   <= valid_next;
            dirty_reg   <= dirty_next;
            align_reg   <= align_next;
            tried_reg   <= tried_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    feba_pkg::CFG_SPWB:       spwb_reg <= cfg_data[8:0];
                    feba_pkg::CFG_CDR_MODE:   cdr_reg  <= cfg_data[0];
                    feba_pkg::CFG_LAST_BLOCK: last_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        start_reg <= start_next;  len_reg <= len_next;  lim_reg <= lim_next;
        count_reg <= count_next;  seq_reg <= seq_next;  mval_reg <= mval_next;
        ps_reg <= ps_next;  i_reg <= i_next;  b_reg <= b_next;  f_reg <= f_next;
        cnt_reg <= cnt_next;  run_reg <= run_next;  end_reg <= end_next;
        mlba_reg <= mlba_next;  mlen_reg <= mlen_next;
        word_reg <= word_next;  waddr_reg <= waddr_next;  cap_reg <= cap_next;
        rs_reg <= rs_next;  rstart_reg <= rstart_next;
        rlen_reg <= rlen_next;  rcount_reg <= rcount_next;
        // hold the output until the transfer completes
        if (state_reg == S_DONE && (!m_valid_reg || m_ready)) begin
            ms_reg  <= rs_reg;
            mst_reg <= rstart_reg;
            ml_reg  <= rlen_reg;
            mc_reg  <= rcount_reg;
        end
    end

endmodule
